[rtl/core/doppler_gain_pitch_defines.svh]
// assertion helpers for the doppler gain / pitch top module
`ifndef DOPPLER_GAIN_PITCH_DEFINES_SVH
`define DOPPLER_GAIN_PITCH_DEFINES_SVH

// antecedent implies consequent in the same cycle, checked outside reset
`define DGP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dgp check failed");

// condition that must hold in the cycle after reset is seen
`define DGP_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("dgp reset check failed");

`endif

[rtl/core/dgp_pkg.sv]
`default_nettype none
package dgp_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED      = 2'd0,
      CSR_GAIN_SCALE = 2'd1,
      CSR_MUTE_FRAC  = 2'd2
   } csr_index_type;

   // field and datapath widths
   localparam int POS_W   = 24;
   localparam int VEL_W   = 20;
   localparam int P_W     = 25;  // relative position
   localparam int U_W     = 21;  // relative velocity
   localparam int SQT_W   = 48;  // one squared term
   localparam int PRD_W   = 46;  // one dot product term
   localparam int SQ_W    = 50;  // sum of squares
   localparam int DOT_W   = 47;  // dot product
   localparam int ABS_W   = 46;  // |dot|
   localparam int ROOT_W  = 25;
   localparam int D_W     = 26;
   localparam int GDEN_W  = 27;
   localparam int C_W     = 19;
   localparam int GS_W    = 20;
   localparam int MF_W    = 16;
   localparam int LIM_W   = 35;
   localparam int OUT_W   = 20;
   localparam int DIVN_W  = 36;
   localparam int PDEN_W  = 20;

   localparam logic [C_W-1:0]  SPEED_RST = 19'd87040;
   localparam logic [GS_W-1:0] GSCALE_RST = 20'd655360;
   localparam logic [MF_W-1:0] MFRAC_RST = 16'd58982;

   localparam logic [OUT_W-1:0] OUT_MAX   = 20'hFFFFF;
   localparam logic [OUT_W-1:0] PITCH_ONE = 20'h10000;
   localparam logic [OUT_W-1:0] LOS_MAX   = 20'h7FFFF;
   localparam logic [OUT_W-1:0] LOS_MIN   = 20'h80000;

endpackage
`default_nettype wire

[rtl/core/dgp_sqrt_cell.sv]
`default_nettype none
// one root bit per cell, radicand consumed two bits at a time
module dgp_sqrt_cell #(
   parameter int XW = 50,
   parameter int SW = 47
) (
   input  logic            clock,
   input  logic            en,
   input  logic [XW-1:0]   x_in,
   input  logic [XW/2:0]   rem_in,
   input  logic [XW/2-1:0] root_in,
   input  logic [SW-1:0]   side_in,
   output logic [XW-1:0]   x_out,
   output logic [XW/2:0]   rem_out,
   output logic [XW/2-1:0] root_out,
   output logic [SW-1:0]   side_out
);
   localparam int RW = XW / 2;

   logic [XW-1:0] x_ff;
   logic [RW:0]   rem_ff, rem_in_nx;
   logic [RW-1:0] root_ff, root_in_nx;
   logic [SW-1:0] side_ff;
   logic [RW+2:0] cand, trial;
   logic [RW+2:0] diff;

   always_comb begin
      cand  = {rem_in, x_in[XW-1:XW-2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = cand - trial;
      if (cand >= trial) begin
         rem_in_nx  = diff[RW:0];
         root_in_nx = {root_in[RW-2:0], 1'b1};
      end else begin
         rem_in_nx  = cand[RW:0];
         root_in_nx = {root_in[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= {x_in[XW-3:0], 2'b00};
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         side_ff <= side_in;
      end
   end

   assign x_out    = x_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

[rtl/core/dgp_div_cell.sv]
`default_nettype none
// restoring division, one quotient bit per cell
module dgp_div_cell #(
   parameter int NW = 36,
   parameter int DW = 27,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [NW-1:0] quot_in,
   input  logic [DW-1:0] rem_in,
   input  logic [DW-1:0] den_in,
   input  logic [SW-1:0] side_in,
   output logic [NW-1:0] num_out,
   output logic [NW-1:0] quot_out,
   output logic [DW-1:0] rem_out,
   output logic [DW-1:0] den_out,
   output logic [SW-1:0] side_out
);
   logic [NW-1:0] num_ff, quot_ff, quot_in_nx;
   logic [DW-1:0] rem_ff, den_ff, rem_in_nx;
   logic [SW-1:0] side_ff;
   logic [DW:0]   cand, diff;

   always_comb begin
      cand = {rem_in, num_in[NW-1]};
      diff = cand - {1'b0, den_in};
      if (cand >= {1'b0, den_in}) begin
         rem_in_nx  = diff[DW-1:0];
         quot_in_nx = {quot_in[NW-2:0], 1'b1};
      end else begin
         rem_in_nx  = cand[DW-1:0];
         quot_in_nx = {quot_in[NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= {num_in[NW-2:0], 1'b0};
         quot_ff <= quot_in_nx;
         rem_ff  <= rem_in_nx;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign num_out  = num_ff;
   assign quot_out = quot_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

[rtl/core/dgp_divider.sv]
`default_nettype none
// row of NW registered division cells
module dgp_divider #(
   parameter int NW = 36,
   parameter int DW = 27,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [SW-1:0] side_in,
   output logic [NW-1:0] quot_out,
   output logic [SW-1:0] side_out
);
   logic [NW-1:0] num_c  [NW+1];
   logic [NW-1:0] quot_c [NW+1];
   logic [DW-1:0] rem_c  [NW+1];
   logic [DW-1:0] den_c  [NW+1];
   logic [SW-1:0] side_c [NW+1];

   assign num_c[0]  = num_in;
   assign quot_c[0] = '0;
   assign rem_c[0]  = '0;
   assign den_c[0]  = den_in;
   assign side_c[0] = side_in;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      dgp_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
         .clock    (clock),
         .en       (en),
         .num_in   (num_c[i]),
         .quot_in  (quot_c[i]),
         .rem_in   (rem_c[i]),
         .den_in   (den_c[i]),
         .side_in  (side_c[i]),
         .num_out  (num_c[i+1]),
         .quot_out (quot_c[i+1]),
         .rem_out  (rem_c[i+1]),
         .den_out  (den_c[i+1]),
         .side_out (side_c[i+1])
      );
   end

   assign quot_out = quot_c[NW];
   assign side_out = side_c[NW];
endmodule
`default_nettype wire

[rtl/core/doppler_gain_pitch.sv]
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_src_*/req_lis_* positions and velocities
// rsp     | out       | rsp_valid, rsp_ready, rsp_gain, rsp_pitch_ratio, rsp_muted,
//         |           | rsp_los_speed
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// one voice per cycle unless a result is held at the output; the pipe is
// built mostly from cell rows: 25 square root cells, 46 cells for the
// line-of-sight division, then gain and pitch division rows of 36 cells each
// reset clears the valid line and loads the register defaults (340.0, 10.0, 0.9)
// a stalled output freezes the whole pipe; req_ready is low only in that case
`default_nettype none
module doppler_gain_pitch #(
   parameter int FRAC_BITS = 8
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic signed [dgp_pkg::POS_W-1:0] req_src_pos_x,
   input  logic signed [dgp_pkg::POS_W-1:0] req_src_pos_y,
   input  logic signed [dgp_pkg::POS_W-1:0] req_src_pos_z,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_src_vel_x,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_src_vel_y,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_src_vel_z,
   input  logic signed [dgp_pkg::POS_W-1:0] req_lis_pos_x,
   input  logic signed [dgp_pkg::POS_W-1:0] req_lis_pos_y,
   input  logic signed [dgp_pkg::POS_W-1:0] req_lis_pos_z,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_lis_vel_x,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_lis_vel_y,
   input  logic signed [dgp_pkg::VEL_W-1:0] req_lis_vel_z,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [dgp_pkg::OUT_W-1:0]        rsp_gain,
   output logic [dgp_pkg::OUT_W-1:0]        rsp_pitch_ratio,
   output logic                             rsp_muted,
   output logic signed [dgp_pkg::OUT_W-1:0] rsp_los_speed,

   input  logic csr_valid,
   output logic csr_ready,
   input  logic [dgp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dgp_pkg::CSR_DATA_W-1:0] csr_data
);
   import dgp_pkg::*;
   `include "doppler_gain_pitch_defines.svh"

   // stages: input, products, sums, sqrt row, d, los row, mute, gain/pitch rows
   localparam int LAT = 3 + ROOT_W + 1 + ABS_W + 1 + DIVN_W;
   localparam logic [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;

   logic en;

   // configuration registers
   logic [C_W-1:0]   speed_ff;
   logic [GS_W-1:0]  gscale_ff;
   logic [MF_W-1:0]  mfrac_ff;
   logic [LIM_W-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_RST;
         gscale_ff <= GSCALE_RST;
         mfrac_ff  <= MFRAC_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED:      speed_ff  <= csr_data[C_W-1:0];
            CSR_GAIN_SCALE: gscale_ff <= csr_data[GS_W-1:0];
            CSR_MUTE_FRAC:  mfrac_ff  <= csr_data[MF_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // mute limit, mute_fraction * c in Q.(FRAC_BITS+16)
   always_ff @(posedge clock) begin
      limit_ff <= LIM_W'(mfrac_ff) * LIM_W'(speed_ff);
   end

   // whole pipe moves unless a finished result is held at the output
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // valid line alongside the datapath
   logic [LAT-1:0] vld_ff;
   logic           rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   // stage 1: relative position and velocity
   logic signed [P_W-1:0] p_ff [3];
   logic signed [U_W-1:0] u_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= P_W'(req_src_pos_x) - P_W'(req_lis_pos_x);
         p_ff[1] <= P_W'(req_src_pos_y) - P_W'(req_lis_pos_y);
         p_ff[2] <= P_W'(req_src_pos_z) - P_W'(req_lis_pos_z);
         u_ff[0] <= U_W'(req_src_vel_x) - U_W'(req_lis_vel_x);
         u_ff[1] <= U_W'(req_src_vel_y) - U_W'(req_lis_vel_y);
         u_ff[2] <= U_W'(req_src_vel_z) - U_W'(req_lis_vel_z);
      end
   end

   // stage 2: squares and dot product terms, one multiplier each
   logic [SQT_W-1:0]        sq_ff   [3];
   logic signed [PRD_W-1:0] prod_ff [3];
   logic signed [2*P_W-1:0] sq_full [3];
   logic signed [PRD_W-1:0] pr_full [3];

   for (genvar k = 0; k < 3; k++) begin : g_mul
      assign sq_full[k] = p_ff[k] * p_ff[k];
      assign pr_full[k] = u_ff[k] * p_ff[k];
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k]   <= sq_full[k][SQT_W-1:0];
            prod_ff[k] <= pr_full[k];
         end
      end
   end

   // stage 3: sums
   logic [SQ_W-1:0]         sumsq_ff;
   logic signed [DOT_W-1:0] dot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sumsq_ff <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
         dot_ff   <= DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1]) + DOT_W'(prod_ff[2]);
      end
   end

   // square root row, dot product rides along
   logic [SQ_W-1:0]   sx_c    [ROOT_W+1];
   logic [ROOT_W:0]   srem_c  [ROOT_W+1];
   logic [ROOT_W-1:0] sroot_c [ROOT_W+1];
   logic [DOT_W-1:0]  sside_c [ROOT_W+1];

   assign sx_c[0]    = sumsq_ff;
   assign srem_c[0]  = '0;
   assign sroot_c[0] = '0;
   assign sside_c[0] = dot_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      dgp_sqrt_cell #(.XW(SQ_W), .SW(DOT_W)) u_cell (
         .clock    (clock),
         .en       (en),
         .x_in     (sx_c[i]),
         .rem_in   (srem_c[i]),
         .root_in  (sroot_c[i]),
         .side_in  (sside_c[i]),
         .x_out    (sx_c[i+1]),
         .rem_out  (srem_c[i+1]),
         .root_out (sroot_c[i+1]),
         .side_out (sside_c[i+1])
      );
   end

   // stage d: d = 1 + distance, and |dot|
   logic [DOT_W-1:0] dot_q, dot_neg;
   logic [D_W-1:0]   d_ff;
   logic [ABS_W-1:0] absdot_ff;
   logic             neg_ff;

   assign dot_q   = sside_c[ROOT_W];
   assign dot_neg = -dot_q;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff      <= ONE_D + D_W'(sroot_c[ROOT_W]);
         neg_ff    <= dot_q[DOT_W-1];
         absdot_ff <= dot_q[DOT_W-1] ? dot_neg[ABS_W-1:0] : dot_q[ABS_W-1:0];
      end
   end

   // line-of-sight division |dot| / d
   logic [ABS_W-1:0] mag;
   logic [D_W:0]     los_side;

   dgp_divider #(.NW(ABS_W), .DW(D_W), .SW(D_W+1)) u_los_div (
      .clock    (clock),
      .en       (en),
      .num_in   (absdot_ff),
      .den_in   (d_ff),
      .side_in  ({neg_ff, d_ff}),
      .quot_out (mag),
      .side_out (los_side)
   );

   // mute stage: limit test, saturated speed, divider operands
   logic              mneg;
   logic [D_W-1:0]    md;
   logic              mag_big, muted_nx;
   logic [OUT_W-1:0]  los_nx;
   logic [OUT_W-1:0]  mag_lo;

   logic              muted_ff;
   logic [OUT_W-1:0]  los_ff;
   logic [DIVN_W-1:0] gnum_ff, pnum_ff;
   logic [GDEN_W-1:0] gden_ff;
   logic [PDEN_W-1:0] pden_ff;

   assign mneg    = los_side[D_W];
   assign md      = los_side[D_W-1:0];
   assign mag_big = |mag[ABS_W-1:OUT_W-1];
   assign mag_lo  = {1'b0, mag[OUT_W-2:0]};

   always_comb begin
      muted_nx = mag_big || ({mag[OUT_W-2:0], 16'b0} >= limit_ff);
      if (mneg) begin
         los_nx = mag_big ? LOS_MIN : -mag_lo;
      end else begin
         los_nx = mag_big ? LOS_MAX : mag_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         muted_ff <= muted_nx;
         los_ff   <= los_nx;
         gnum_ff  <= DIVN_W'(gscale_ff) << FRAC_BITS;
         gden_ff  <= GDEN_W'(ONE_D) + GDEN_W'(md);
         pnum_ff  <= {1'b0, speed_ff, 16'b0};
         // c + v; only meaningful when not muted, then it lies in (0, 2c)
         pden_ff  <= mneg ? ({1'b0, speed_ff} - mag_lo) : ({1'b0, speed_ff} + mag_lo);
      end
   end

   // gain and pitch divisions side by side
   logic [DIVN_W-1:0] gquot, pquot;
   logic              gmuted;
   logic [OUT_W-1:0]  plos;

   dgp_divider #(.NW(DIVN_W), .DW(GDEN_W), .SW(1)) u_gain_div (
      .clock    (clock),
      .en       (en),
      .num_in   (gnum_ff),
      .den_in   (gden_ff),
      .side_in  (muted_ff),
      .quot_out (gquot),
      .side_out (gmuted)
   );

   dgp_divider #(.NW(DIVN_W), .DW(PDEN_W), .SW(OUT_W)) u_pitch_div (
      .clock    (clock),
      .en       (en),
      .num_in   (pnum_ff),
      .den_in   (pden_ff),
      .side_in  (los_ff),
      .quot_out (pquot),
      .side_out (plos)
   );

   // output register
   logic [OUT_W-1:0] gain_ff, pitch_ff, losout_ff;
   logic             mutedout_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mutedout_ff <= gmuted;
         losout_ff   <= plos;
         if (gmuted) begin
            gain_ff  <= '0;
            pitch_ff <= PITCH_ONE;
         end else begin
            gain_ff  <= (|gquot[DIVN_W-1:OUT_W]) ? OUT_MAX : gquot[OUT_W-1:0];
            pitch_ff <= (|pquot[DIVN_W-1:OUT_W]) ? OUT_MAX : pquot[OUT_W-1:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gain        = gain_ff;
   assign rsp_pitch_ratio = pitch_ff;
   assign rsp_muted       = mutedout_ff;
   assign rsp_los_speed   = losout_ff;

   // muted voice carries fixed outputs
   `DGP_ASSERT_IMPLY(a_mute_outputs, clock, reset, rsp_valid && rsp_muted, rsp_gain == '0 && rsp_pitch_ratio == PITCH_ONE)
   // gain_scale / (2 + distance) stays below half of the range
   `DGP_ASSERT_IMPLY(a_gain_range, clock, reset, rsp_valid && !rsp_muted, !rsp_gain[OUT_W-1])
   // an unmuted speed is under 2^19 in magnitude, so never at the negative rail
   `DGP_ASSERT_IMPLY(a_los_range, clock, reset, rsp_valid && !rsp_muted, rsp_los_speed != LOS_MIN)
   `DGP_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid)
endmodule
`default_nettype wire
